// ----- design/kmi_pkg.sv -----
// Shared types and constants for the keyframe matrix interpolator.
// Used by kmi_ctrl, kmi_datapath, keyframe_matrix_interpolator and the testbench.
`default_nettype none
package kmi_pkg;

    // Operation codes of an input transaction
    localparam logic [1:0] OP_WR_ELEM  = 2'd0;
    localparam logic [1:0] OP_WR_DUR   = 2'd1;
    localparam logic [1:0] OP_Q_TIME   = 2'd2;
    localparam logic [1:0] OP_Q_PROP   = 2'd3;

    // Configuration register indexes
    localparam logic [1:0] CFG_STEP_COUNT = 2'd0;
    localparam logic [1:0] CFG_SPEED      = 2'd1;
    localparam logic [1:0] CFG_LEAD_IN    = 2'd2;

    localparam int ELEMENTS = 16;
    localparam int EIW      = 4;    // element index width
    localparam int DW       = 20;   // duration width
    localparam int CW       = 56;   // time position width, 1/65536 ms units
    localparam int NW       = 37;   // divider numerator width
    localparam int QW       = 17;   // proportion width, Q0.16 plus one
    localparam int DCW      = 5;    // divider step counter width
    localparam logic [QW-1:0]  P_ONE     = 17'h10000;
    localparam logic [EIW-1:0] ELEM_LAST = 4'd15;
    localparam logic [DCW-1:0] DIV_LAST  = 5'd16;

    // Controller to datapath commands
    typedef struct packed {
        logic mem_wr;
        logic load_query;
        logic cur_mul;
        logic cur_sub;
        logic sum_acc;
        logic cur_prop;
        logic seg_next;
        logic div_init;
        logic div_step;
        logic emit_rd;
        logic emit_mul;
        logic emit_out;
        logic emit_nf;
    } t_cmd;

    // Datapath to controller status
    typedef struct packed {
        logic pre_start;
        logic cnt_done;
        logic hit;
        logic dzero;
        logic div_last;
        logic last_elem;
        logic out_free;
        logic prop_over;
    } t_stat;

endpackage
`default_nettype wire

// ----- design/kmi_ctrl.sv -----
// Controller state machine of the keyframe matrix interpolator.
// Depends on kmi_pkg for the command, status and operation codes.
`default_nettype none
module kmi_ctrl (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_valid,
    input  wire logic [1:0]    i_op,
    output logic               o_ready,
    input  wire kmi_pkg::t_stat i_stat,
    output kmi_pkg::t_cmd      o_cmd
);
    import kmi_pkg::*;

    typedef enum logic [12:0] {
        S_IDLE   = 13'b0000000000001,
        S_MULE   = 13'b0000000000010,
        S_SUBE   = 13'b0000000000100,
        S_SUMRD  = 13'b0000000001000,
        S_SUMACC = 13'b0000000010000,
        S_PMUL   = 13'b0000000100000,
        S_SRD    = 13'b0000001000000,
        S_SCHK   = 13'b0000010000000,
        S_DIV    = 13'b0000100000000,
        S_ERD    = 13'b0001000000000,
        S_EMUL   = 13'b0010000000000,
        S_EOUT   = 13'b0100000000000,
        S_NF     = 13'b1000000000000
    } t_state;

    t_state r_state, n_state;
    logic   acc;

    assign o_ready = (r_state == S_IDLE);
    assign acc     = o_ready && i_valid;

    // Decode next state and commands
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (acc) begin
                    if (i_op == OP_WR_ELEM || i_op == OP_WR_DUR) begin
                        o_cmd.mem_wr = 1'b1;
                    end else begin
                        o_cmd.load_query = 1'b1;
                        if (i_op == OP_Q_TIME) n_state = S_MULE;
                        else if (i_stat.prop_over) n_state = S_NF;
                        else n_state = S_SUMRD;
                    end
                end
            end
            S_MULE: begin
                o_cmd.cur_mul = 1'b1;
                n_state = S_SUBE;
            end
            S_SUBE: begin
                o_cmd.cur_sub = 1'b1;
                n_state = i_stat.pre_start ? S_ERD : S_SRD;
            end
            S_SUMRD: begin
                n_state = i_stat.cnt_done ? S_PMUL : S_SUMACC;
            end
            S_SUMACC: begin
                o_cmd.sum_acc = 1'b1;
                n_state = S_SUMRD;
            end
            S_PMUL: begin
                o_cmd.cur_prop = 1'b1;
                n_state = S_SRD;
            end
            S_SRD: begin
                n_state = i_stat.cnt_done ? S_NF : S_SCHK;
            end
            S_SCHK: begin
                if (i_stat.hit) begin
                    o_cmd.div_init = 1'b1;
                    n_state = i_stat.dzero ? S_ERD : S_DIV;
                end else begin
                    o_cmd.seg_next = 1'b1;
                    n_state = S_SRD;
                end
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                if (i_stat.div_last) n_state = S_ERD;
            end
            S_ERD: begin
                o_cmd.emit_rd = 1'b1;
                n_state = S_EMUL;
            end
            S_EMUL: begin
                o_cmd.emit_mul = 1'b1;
                n_state = S_EOUT;
            end
            S_EOUT: begin
                if (i_stat.out_free) begin
                    o_cmd.emit_out = 1'b1;
                    n_state = i_stat.last_elem ? S_IDLE : S_ERD;
                end
            end
            S_NF: begin
                if (i_stat.out_free) begin
                    o_cmd.emit_nf = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Advance state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= S_IDLE;
        else r_state <= n_state;
    end

endmodule
`default_nettype wire

// ----- design/kmi_datapath.sv -----
// Datapath of the keyframe matrix interpolator: stores, config registers,
// time arithmetic, segment walk, serial divider, blend and output register.
// Depends on kmi_pkg.
`default_nettype none
module kmi_datapath #(
    parameter int MAX_POINTS = 32
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_cfg_valid,
    input  wire logic [1:0]            i_cfg_index,
    input  wire logic [19:0]           i_cfg_data,
    input  wire logic [1:0]            i_op,
    input  wire logic [4:0]            i_point_index,
    input  wire logic [3:0]            i_element_index,
    input  wire logic signed [31:0]    i_element_value,
    input  wire logic [19:0]           i_duration,
    input  wire logic [31:0]           i_elapsed,
    input  wire logic [16:0]           i_proportion,
    input  wire kmi_pkg::t_cmd         i_cmd,
    output kmi_pkg::t_stat             o_stat,
    input  wire logic                  i_ready,
    output logic                       o_valid,
    output logic [3:0]                 o_out_index,
    output logic signed [31:0]         o_out_value,
    output logic                       o_found,
    output logic                       o_last
);
    import kmi_pkg::*;

    localparam int PW    = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
    localparam int AW    = PW + EIW;
    localparam int DEPTH = MAX_POINTS * ELEMENTS;
    localparam int TW    = DW + PW;

    logic [31:0]    kf_mem [DEPTH];
    logic [DW-1:0]  dur_mem [MAX_POINTS];

    logic [4:0]     r_step;
    logic [15:0]    r_speed;
    logic [19:0]    r_lead;

    logic [31:0]    r_elapsed;
    logic [15:0]    r_prop;
    logic [PW-1:0]  r_cnt;
    logic [TW-1:0]  r_total;
    logic [TW-1:0]  r_start;
    logic [CW-1:0]  r_cur;
    logic [DW-1:0]  r_dur;
    logic [DW-1:0]  r_d;
    logic [DW-1:0]  r_rem;
    logic [QW-1:0]  r_qs;
    logic [DCW-1:0] r_dcnt;
    logic [PW-1:0]  r_kf;
    logic [EIW-1:0] r_j;
    logic [31:0]    r_a;
    logic [31:0]    r_b;
    logic signed [50:0] r_prod;

    logic [PW-1:0]  n_used;
    logic [PW-1:0]  wr_pt;
    logic           wr_ok;
    logic [15:0]    sp;
    logic [47:0]    now_raw;
    logic [16+TW-1:0] prop_prod;
    logic [CW-1:0]  lead_x;
    logic [CW-1:0]  start_x;
    logic [TW-1:0]  seg_end;
    logic [CW-1:0]  end_x;
    logic [CW-1:0]  num_w;
    logic [NW-1:0]  num;
    logic [DW:0]    rem2;
    logic           ge;
    logic [PW:0]    kf1;
    logic [PW-1:0]  nx;
    logic [QW-1:0]  p_eff;
    logic signed [32:0] diff;
    logic signed [50:0] blend;

    // Decode write target and used segment count
    assign wr_ok   = (32'(i_point_index) < MAX_POINTS);
    assign wr_pt   = PW'(i_point_index);
    assign n_used  = (32'(r_step) > MAX_POINTS - 1) ? PW'(MAX_POINTS - 1) : PW'(r_step);
    assign sp      = (r_speed == 16'd0) ? 16'd1 : r_speed;
    assign now_raw = r_elapsed * sp;
    assign prop_prod = r_prop * r_total;
    assign lead_x  = CW'({r_lead, 16'b0});
    assign start_x = CW'({r_start, 16'b0});
    assign seg_end = r_start + TW'(r_dur);
    assign end_x   = CW'({seg_end, 16'b0});
    assign num_w   = r_cur - start_x;
    assign num     = num_w[NW-1:0];
    assign rem2    = {r_rem, r_qs[QW-1]};
    assign ge      = (rem2 >= {1'b0, r_d});
    assign kf1     = {1'b0, r_kf} + 1'b1;
    assign nx      = (32'(kf1) < MAX_POINTS) ? kf1[PW-1:0] : r_kf;
    assign p_eff   = (r_qs > P_ONE) ? P_ONE : r_qs;
    assign diff    = $signed({r_b[31], r_b}) - $signed({r_a[31], r_a});
    assign blend   = $signed({{19{r_a[31]}}, r_a}) + (r_prod >>> 16);

    assign o_stat.pre_start = (r_cur < lead_x);
    assign o_stat.cnt_done  = (r_cnt == n_used);
    assign o_stat.hit       = (start_x <= r_cur) && (r_cur <= end_x);
    assign o_stat.dzero     = (r_dur == '0);
    assign o_stat.div_last  = (r_dcnt == DIV_LAST);
    assign o_stat.last_elem = (r_j == ELEM_LAST);
    assign o_stat.out_free  = !o_valid || i_ready;
    assign o_stat.prop_over = i_proportion[QW-1];

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step  <= '0;
            r_speed <= 16'd256;
            r_lead  <= '0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_STEP_COUNT: r_step  <= i_cfg_data[4:0];
                CFG_SPEED:      r_speed <= i_cfg_data[15:0];
                CFG_LEAD_IN:    r_lead  <= i_cfg_data;
                default:        ;
            endcase
        end
    end

    // Keyframe store: one write port, two registered read ports
    always_ff @(posedge i_clk) begin
        if (i_cmd.mem_wr && i_op == OP_WR_ELEM && wr_ok)
            kf_mem[{wr_pt, i_element_index}] <= i_element_value;
        if (i_cmd.emit_rd) begin
            r_a <= kf_mem[AW'({r_kf, r_j})];
            r_b <= kf_mem[AW'({nx, r_j})];
        end
    end

    // Duration store: read at the walk counter every cycle
    always_ff @(posedge i_clk) begin
        if (i_cmd.mem_wr && i_op == OP_WR_DUR && wr_ok)
            dur_mem[wr_pt] <= i_duration;
        r_dur <= dur_mem[r_cnt];
    end

    // Time position, segment walk and divider
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_query) begin
            r_elapsed <= i_elapsed;
            r_prop    <= i_proportion[15:0];
            r_cnt     <= '0;
            r_total   <= '0;
            r_start   <= '0;
            r_j       <= '0;
        end
        if (i_cmd.cur_mul) r_cur <= CW'({now_raw, 8'b0});
        if (i_cmd.cur_sub) begin
            if (o_stat.pre_start) begin
                r_kf <= '0;
                r_qs <= '0;
            end else begin
                r_cur <= r_cur - lead_x;
            end
        end
        if (i_cmd.sum_acc) begin
            r_total <= r_total + TW'(r_dur);
            r_cnt   <= r_cnt + 1'b1;
        end
        if (i_cmd.cur_prop) begin
            r_cur <= CW'(prop_prod);
            r_cnt <= '0;
        end
        if (i_cmd.seg_next) begin
            r_start <= seg_end;
            r_cnt   <= r_cnt + 1'b1;
        end
        if (i_cmd.div_init) begin
            r_kf   <= r_cnt;
            r_d    <= r_dur;
            r_rem  <= num[NW-1:QW];
            r_qs   <= (r_dur == '0) ? '0 : num[QW-1:0];
            r_dcnt <= '0;
        end
        if (i_cmd.div_step) begin
            r_rem  <= ge ? DW'(rem2 - {1'b0, r_d}) : rem2[DW-1:0];
            r_qs   <= {r_qs[QW-2:0], ge};
            r_dcnt <= r_dcnt + 1'b1;
        end
        if (i_cmd.emit_mul)
            r_prod <= $signed({1'b0, p_eff}) * diff;
        if (i_cmd.emit_out) r_j <= r_j + 1'b1;
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else if (i_cmd.emit_out || i_cmd.emit_nf) begin
            o_valid <= 1'b1;
        end else if (i_ready) begin
            o_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit_out) begin
            o_out_index <= r_j;
            o_out_value <= blend[31:0];
            o_found     <= 1'b1;
            o_last      <= (r_j == ELEM_LAST);
        end else if (i_cmd.emit_nf) begin
            o_out_index <= '0;
            o_out_value <= '0;
            o_found     <= 1'b0;
            o_last      <= 1'b1;
        end
    end

endmodule
`default_nettype wire

// ----- design/keyframe_matrix_interpolator.sv -----
// Top level of the keyframe matrix interpolator: controller plus datapath.
// Depends on kmi_pkg, kmi_ctrl and kmi_datapath.
//
// Usage: the input channel (i_valid/o_ready) carries one transaction per op.
// Element and duration writes give no result and leave the block ready. A query
// gives 16 results (one per matrix element, o_last on the final one), or a
// single not-found result with o_found low. Configuration writes go through
// i_cfg_valid/o_cfg_ready, always ready; write them only while idle.
// An elapsed query scales the time, subtracts the lead-in and then walks
// the segments one by one; a proportion query first sums the durations of
// the used segments. A hit then runs the divider (one quotient bit per cycle),
// and each element passes store read, multiply and blend into the output
// register. The worst case is set by the sequential segment walk over the
// single duration read port and by the serial divider.
// One query is in flight at a time; the next is accepted once the last
// result sits in the output register. Reset clears control and config
// registers (speed returns to 1.0); the stores are undefined until written.
// A stalled receiver holds the output register and the block waits.
`default_nettype none
module keyframe_matrix_interpolator #(
    parameter int MAX_POINTS = 32
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_cfg_valid,
    output logic                    o_cfg_ready,
    input  wire logic [1:0]         i_cfg_index,
    input  wire logic [19:0]        i_cfg_data,
    input  wire logic               i_valid,
    output logic                    o_ready,
    input  wire logic [1:0]         i_op,
    input  wire logic [4:0]         i_point_index,
    input  wire logic [3:0]         i_element_index,
    input  wire logic signed [31:0] i_element_value,
    input  wire logic [19:0]        i_duration,
    input  wire logic [31:0]        i_elapsed,
    input  wire logic [16:0]        i_proportion,
    output logic                    o_valid,
    input  wire logic               i_ready,
    output logic [3:0]              o_out_index,
    output logic signed [31:0]      o_out_value,
    output logic                    o_found,
    output logic                    o_last
);
    import kmi_pkg::*;

    t_cmd  cmd;
    t_stat stat;

    assign o_cfg_ready = 1'b1;

    // Sequence the query
    kmi_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .i_op    (i_op),
        .o_ready (o_ready),
        .i_stat  (stat),
        .o_cmd   (cmd)
    );

    // Store, compute and hold results
    kmi_datapath #(
        .MAX_POINTS (MAX_POINTS)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_valid     (i_cfg_valid),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_op            (i_op),
        .i_point_index   (i_point_index),
        .i_element_index (i_element_index),
        .i_element_value (i_element_value),
        .i_duration      (i_duration),
        .i_elapsed       (i_elapsed),
        .i_proportion    (i_proportion),
        .i_cmd           (cmd),
        .o_stat          (stat),
        .i_ready         (i_ready),
        .o_valid         (o_valid),
        .o_out_index     (o_out_index),
        .o_out_value     (o_out_value),
        .o_found         (o_found),
        .o_last          (o_last)
    );

`ifndef SYNTHESIS
    // A not-found result is a single zero transaction
    a_nf_shape: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_found) |-> (o_last && o_out_value == 32'sd0 && o_out_index == 4'd0))
        else $error("not-found result malformed");

    // The final element of a found query carries the last flag
    a_last_idx: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_found) |-> (o_last == (o_out_index == 4'd15)))
        else $error("last flag does not match element index");

    // A query keeps the block busy for the next cycle
    a_query_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready && (i_op == OP_Q_TIME || i_op == OP_Q_PROP)) |=> !o_ready)
        else $error("query accepted without going busy");

    // A write never leaves the block busy
    a_write_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready && (i_op == OP_WR_ELEM || i_op == OP_WR_DUR)) |=> o_ready)
        else $error("write left the block busy");
`endif

endmodule
`default_nettype wire

// ----- tb/kmi_checker.sv -----
// Checker for the keyframe matrix interpolator: watches the configuration,
// input and result channels, predicts results from its own copy of the stores and registers, compares.
// Depends on kmi_pkg.
`timescale 1ns / 1ps
module kmi_checker (
    input  wire logic               clk,
    input  wire logic               cfg_fire,
    input  wire logic [1:0]         cfg_index,
    input  wire logic [19:0]        cfg_data,
    input  wire logic               in_fire,
    input  wire logic [1:0]         op,
    input  wire logic [4:0]         point_index,
    input  wire logic [3:0]         element_index,
    input  wire logic signed [31:0] element_value,
    input  wire logic [19:0]        duration,
    input  wire logic [31:0]        elapsed,
    input  wire logic [16:0]        proportion,
    input  wire logic               out_fire,
    input  wire logic [3:0]         out_index,
    input  wire logic signed [31:0] out_value,
    input  wire logic               found,
    input  wire logic               last,
    output int                      fail_count,
    output int                      pending
);
    import kmi_pkg::*;

    typedef struct packed {
        logic [3:0]         idx;
        logic signed [31:0] val;
        logic               fnd;
        logic               lst;
    } t_frame_elem;

    localparam int NPTS = 32;

    logic signed [31:0] kf_mem [NPTS*ELEMENTS];
    logic [19:0]        dur_mem [NPTS];
    logic [4:0]         steps_reg;
    logic [15:0]        speed_reg;
    logic [19:0]        lead_reg;
    t_frame_elem        expected_frames[$];

    initial begin
        fail_count = 0;
        steps_reg  = '0;
        speed_reg  = 16'd256;
        lead_reg   = '0;
    end

    assign pending = expected_frames.size();

    // Queue the 16 blended elements of one segment
    task automatic push_frame(input int kf, input longint p);
        int nx;
        longint a, b, v;
        t_frame_elem e;
        nx = (kf + 1 < NPTS) ? kf + 1 : kf;
        for (int j = 0; j < ELEMENTS; j++) begin
            a = kf_mem[kf*ELEMENTS + j];
            b = kf_mem[nx*ELEMENTS + j];
            v = (65536 - p) * a + p * b;
            v = v >>> 16;
            e.idx = j[3:0];
            e.val = v[31:0];
            e.fnd = 1'b1;
            e.lst = (j == ELEMENTS - 1);
            expected_frames.push_back(e);
        end
    endtask

    task automatic push_not_found();
        t_frame_elem e;
        e = '{idx: 4'd0, val: 32'sd0, fnd: 1'b0, lst: 1'b1};
        expected_frames.push_back(e);
    endtask

    // Locate the segment holding the query point and queue its results, or a not-found result
    task automatic predict_query();
        longint unsigned sp, now_t, lead_t, cur, total, seg_start, seg_end, d, p;
        int n;
        bit done;
        n = steps_reg;
        done = 0;
        seg_start = 0;
        if (op == OP_Q_TIME) begin
            sp = (speed_reg == 0) ? 1 : speed_reg;
            now_t = longint'(elapsed) * sp * 256;
            lead_t = longint'(lead_reg) * 65536;
            if (now_t < lead_t) begin
                push_frame(0, 0);
                return;
            end
            cur = now_t - lead_t;
        end else begin
            if (proportion >= P_ONE) begin
                push_not_found();
                return;
            end
            total = 0;
            for (int i = 0; i < n; i++) total += dur_mem[i];
            cur = longint'(proportion) * total;
        end
        for (int i = 0; i < n && !done; i++) begin
            d = dur_mem[i];
            seg_end = seg_start + d * 65536;
            if (seg_start <= cur && cur <= seg_end) begin
                p = (d == 0) ? 0 : (cur - seg_start) / d;
                if (p > 65536) p = 65536;
                push_frame(i, p);
                done = 1;
            end
            seg_start = seg_end;
        end
        if (!done) push_not_found();
    endtask

    // Track register writes and input transactions
    always @(posedge clk) begin
        if (cfg_fire) begin
            case (cfg_index)
                CFG_STEP_COUNT: steps_reg <= cfg_data[4:0];
                CFG_SPEED:      speed_reg <= cfg_data[15:0];
                CFG_LEAD_IN:    lead_reg  <= cfg_data;
                default: ;
            endcase
        end
        if (in_fire) begin
            case (op)
                OP_WR_ELEM: kf_mem[point_index*ELEMENTS + element_index] = element_value;
                OP_WR_DUR:  dur_mem[point_index] = duration;
                default:    predict_query();
            endcase
        end
    end

    // Compare each result transaction with the oldest expectation
    always @(posedge clk) begin
        t_frame_elem e;
        if (out_fire) begin
            if (expected_frames.size() == 0) begin
                $error("unexpected result: index %0d value %0d", out_index, out_value);
                fail_count++;
            end else begin
                e = expected_frames.pop_front();
                if (out_index !== e.idx) begin
                    $error("out_index expected %0d actual %0d", e.idx, out_index);
                    fail_count++;
                end
                if (out_value !== e.val) begin
                    $error("out_value expected %0d actual %0d", e.val, out_value);
                    fail_count++;
                end
                if (found !== e.fnd) begin
                    $error("found expected %0d actual %0d", e.fnd, found);
                    fail_count++;
                end
                if (last !== e.lst) begin
                    $error("last expected %0d actual %0d", e.lst, last);
                    fail_count++;
                end
            end
        end
    end
endmodule

// ----- tb/testbench.sv -----
// Top of the keyframe matrix interpolator testbench: clock, reset, stimulus
// and verdict. Depends on kmi_pkg, kmi_checker and the design.
`timescale 1ns / 1ps
module testbench;
    import kmi_pkg::*;

    // Keyframes filled at start; step counts stay below this
    localparam int KF_USED = 6;

    logic               clk, rst_n;
    logic               cfg_valid, cfg_ready;
    logic [1:0]         cfg_index;
    logic [19:0]        cfg_data;
    logic               in_valid, in_ready;
    logic [1:0]         op;
    logic [4:0]         point_index;
    logic [3:0]         element_index;
    logic signed [31:0] element_value;
    logic [19:0]        duration;
    logic [31:0]        elapsed;
    logic [16:0]        proportion;
    logic               out_valid, out_ready;
    logic [3:0]         out_index;
    logic signed [31:0] out_value;
    logic               found, last;
    int                 fail_count, pending;
    int                 send_idle_pct, recv_idle_pct;
    bit                 recv_hold;

    keyframe_matrix_interpolator dut (
        .i_clk(clk), .i_rst_n(rst_n),
        .i_cfg_valid(cfg_valid), .o_cfg_ready(cfg_ready),
        .i_cfg_index(cfg_index), .i_cfg_data(cfg_data),
        .i_valid(in_valid), .o_ready(in_ready),
        .i_op(op), .i_point_index(point_index), .i_element_index(element_index),
        .i_element_value(element_value), .i_duration(duration),
        .i_elapsed(elapsed), .i_proportion(proportion),
        .o_valid(out_valid), .i_ready(out_ready),
        .o_out_index(out_index), .o_out_value(out_value),
        .o_found(found), .o_last(last)
    );

    kmi_checker u_checker (
        .clk(clk),
        .cfg_fire(cfg_valid && cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .in_fire(in_valid && in_ready), .op(op), .point_index(point_index),
        .element_index(element_index), .element_value(element_value),
        .duration(duration), .elapsed(elapsed), .proportion(proportion),
        .out_fire(out_valid && out_ready), .out_index(out_index),
        .out_value(out_value), .found(found), .last(last),
        .fail_count(fail_count), .pending(pending)
    );

    initial begin
        clk = 0;
        forever #2 clk = ~clk;
    end

    initial begin
        #20ms;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // Receiver: random stalls, or a long hold-off when asked
    always @(posedge clk) begin
        if (recv_hold) out_ready <= 1'b0;
        else out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // Offer one transaction and hold it until accepted; valid stays up after
    // acceptance so the next transaction can follow, drain drops it
    task automatic send_item(input logic [1:0] o, input logic [4:0] pi, input logic [3:0] ei,
                             input logic [31:0] ev, input logic [19:0] du,
                             input logic [31:0] el, input logic [16:0] pr);
        while ($urandom_range(99) < send_idle_pct) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        op <= o; point_index <= pi; element_index <= ei;
        element_value <= ev; duration <= du; elapsed <= el; proportion <= pr;
        do @(posedge clk); while (!in_ready);
    endtask

    task automatic write_elem(input int pi, input int ei, input logic [31:0] v);
        send_item(OP_WR_ELEM, pi[4:0], ei[3:0], v, 20'($urandom), $urandom, 17'($urandom));
    endtask

    task automatic write_dur(input int pi, input logic [19:0] d);
        send_item(OP_WR_DUR, pi[4:0], 4'($urandom), $urandom, d, $urandom, 17'($urandom));
    endtask

    task automatic query_time(input logic [31:0] el);
        send_item(OP_Q_TIME, 5'($urandom), 4'($urandom), $urandom, 20'($urandom), el,
                  17'($urandom));
    endtask

    task automatic query_prop(input logic [16:0] pr);
        send_item(OP_Q_PROP, 5'($urandom), 4'($urandom), $urandom, 20'($urandom), $urandom,
                  pr);
    endtask

    // Drop valid, wait for every expected result, then let the block settle
    task automatic drain();
        in_valid  <= 1'b0;
        cfg_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (150) @(posedge clk);
    endtask

    // Offer one register write; drain drops valid afterwards
    task automatic write_reg(input logic [1:0] idx, input logic [19:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge clk); while (!cfg_ready);
    endtask

    function automatic logic [31:0] rand_value();
        case ($urandom_range(3))
            0: return 32'h8000_0000;
            1: return 32'h7fff_ffff;
            default: return $urandom;
        endcase
    endfunction

    // Random query whose time falls mostly inside the animation
    task automatic random_query();
        if ($urandom_range(1)) begin
            if ($urandom_range(9) == 0) query_prop(17'($urandom_range(65536, 131071)));
            else query_prop(17'($urandom_range(65536)));
        end else begin
            case ($urandom_range(3))
                0: query_time($urandom);
                1: query_time($urandom_range(200000));
                default: query_time($urandom_range(4000));
            endcase
        end
    endtask

    // Fill the keyframes and durations that queries can reach
    task automatic fill_all(input int dmax);
        for (int k = 0; k < KF_USED; k++)
            for (int j = 0; j < ELEMENTS; j++) write_elem(k, j, rand_value());
        for (int k = 0; k < KF_USED; k++) write_dur(k, 20'($urandom_range(dmax)));
    endtask

    initial begin
        rst_n = 0; cfg_valid = 0; cfg_index = '0; cfg_data = '0;
        in_valid = 0; op = '0; point_index = '0; element_index = '0;
        element_value = '0; duration = '0; elapsed = '0; proportion = '0;
        out_ready = 0; recv_hold = 0;
        send_idle_pct = 0; recv_idle_pct = 0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: extremes, zero-length segment, before start, past end
        send_idle_pct = 14; recv_idle_pct = 59;
        fill_all(1000);
        write_elem(0, 0, 32'h8000_0000);
        write_elem(1, 0, 32'h7fff_ffff);
        write_dur(3, 20'hfffff);
        write_dur(2, 20'd0);
        drain();
        query_prop(17'd0);                      // step_count zero: not found
        drain();
        write_reg(CFG_STEP_COUNT, 20'd4);
        write_reg(CFG_LEAD_IN, 20'd100);
        drain();
        query_time(32'd0);                      // before start
        query_time(32'd100);
        query_time(32'hffff_ffff);              // past end
        query_prop(17'd65536);
        query_prop(17'd65535);
        query_prop(17'd32768);
        drain();
        write_reg(CFG_SPEED, 20'd0);            // zero speed acts as one
        write_reg(CFG_LEAD_IN, 20'hfffff);
        drain();
        query_time(32'hffff_ffff);
        query_time(32'd5);
        drain();
        write_reg(CFG_SPEED, 20'hffff);
        write_reg(CFG_LEAD_IN, 20'd0);
        write_reg(CFG_STEP_COUNT, 20'(KF_USED - 1));
        drain();
        query_time(32'd1);
        query_prop(17'd1);

        // Random phases with different settings and idling profiles
        for (int ph = 0; ph < 6; ph++) begin
            drain();
            if (ph == 2) begin send_idle_pct = 59; recv_idle_pct = 14; end
            if (ph == 4) begin send_idle_pct = 0;  recv_idle_pct = 0;  end
            write_reg(CFG_STEP_COUNT, 20'($urandom_range(KF_USED - 1)));
            write_reg(CFG_SPEED, (ph == 1) ? 20'd1 : 20'($urandom_range(1, 2048)));
            write_reg(CFG_LEAD_IN, (ph == 5) ? 20'hfffff : 20'($urandom_range(3000)));
            drain();
            if (ph == 3) begin
                // Hold off the receiver while queries keep coming
                fork
                    begin recv_hold = 1; repeat (300) @(posedge clk); recv_hold = 0; end
                    repeat (4) random_query();
                join
            end
            for (int k = 0; k < 16; k++) begin
                case ($urandom_range(9))
                    0: write_elem($urandom_range(KF_USED - 1), $urandom_range(15),
                                  rand_value());
                    1: write_dur($urandom_range(31), ($urandom_range(7) == 0) ?
                                 20'd0 : 20'($urandom_range(5000)));
                    default: random_query();
                endcase
            end
        end

        drain();
        if (fail_count == 0) $display("SCOREBOARD CLEAN");
        else $display("SCOREBOARD MISMATCH");
        $finish;
    end
endmodule

// ----- keyframe_matrix_interpolator.f -----
design/kmi_pkg.sv
design/kmi_ctrl.sv
design/kmi_datapath.sv
design/keyframe_matrix_interpolator.sv
tb/kmi_checker.sv
tb/testbench.sv
